// File: sv/fltpw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpw_pkg
// shared types and constants of the four-level page table walker
// ----------------------------------------------------------------------------
package fltpw_pkg;

  localparam int unsigned VaW    = 48;
  localparam int unsigned PaW    = 52;
  localparam int unsigned EntryW = 64;
  localparam int unsigned IdxW   = 9;

  // bit positions inside a table entry
  localparam int unsigned BitPresent = 0;
  localparam int unsigned BitLarge   = 7;

  // virtual address index shifts per level
  localparam int unsigned ShiftPml4 = 39;
  localparam int unsigned ShiftPdpt = 30;
  localparam int unsigned ShiftPd   = 21;
  localparam int unsigned ShiftPt   = 12;

  // input function codes
  localparam logic FUNC_TRANSLATE = 1'b0;
  localparam logic FUNC_ENTRY     = 1'b1;

  // result kind codes
  localparam logic KIND_READ = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  typedef enum logic [1:0] {
    LVL_PML4 = 2'd0,
    LVL_PDPT = 2'd1,
    LVL_PD   = 2'd2,
    LVL_PT   = 2'd3
  } level_t;

  typedef struct packed {
    logic             busy;
    level_t           level;
    logic [VaW-1:0]   saved_va;
  } walk_state_t;

  typedef struct packed {
    logic             kind;
    logic [PaW-1:0]   address;
    logic             fault;
  } walk_result_t;

endpackage

// File: sv/four_level_page_table_walker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_level_page_table_walker_unit
// x86-64 four-level page walk: turns translate requests and returned table
// entries into entry read requests and finished translations
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_ready  func, virtual_address, entry_value,
//                                           read_error
//  out      output     out_valid/out_ready  kind, address, fault
//  cfg      input      cfg_wr_en            cfg_wr_data (table base)
//
//  one beat per cycle while out_ready stays high; a beat's result is registered
//  in the result register and can leave once out_ready is high
//  walk state lives next to the step logic and is updated as each beat
//  leaves the input register, so back-to-back beats see each other in order
//  a stalled result register holds the input register, and in_ready drops
//  only when both are full and out_ready is low
//  synchronous active-low reset clears valid flags, walk state and table base
// ----------------------------------------------------------------------------
module four_level_page_table_walker_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_wr_en,
  input  logic [fltpw_pkg::PaW-1:0]         cfg_wr_data,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_func,
  input  logic [fltpw_pkg::VaW-1:0]         in_virtual_address,
  input  logic [fltpw_pkg::EntryW-1:0]      in_entry_value,
  input  logic                              in_read_error,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_kind,
  output logic [fltpw_pkg::PaW-1:0]         out_address,
  output logic                              out_fault
);

  // table base register
  logic [fltpw_pkg::PaW-1:0]      table_base_r;

  // input register
  logic                           in_vld_r;
  logic                           func_r;
  logic [fltpw_pkg::VaW-1:0]      va_r;
  logic [fltpw_pkg::EntryW-1:0]   entry_r;
  logic                           rerr_r;

  // walk state
  fltpw_pkg::walk_state_t         walk_r;
  fltpw_pkg::walk_state_t         walk_nxt;

  // result register
  logic                           out_vld_r;
  fltpw_pkg::walk_result_t        res_r;
  fltpw_pkg::walk_result_t        res_nxt;
  logic                           has_res;

  logic                           step_go;
  logic                           in_beat;

  // the staged beat moves on when the result register is free or draining
  assign step_go  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || step_go;
  assign in_beat  = in_valid && in_ready;

  fltpw_step u_step (
    .func            (func_r),
    .virtual_address (va_r),
    .entry_value     (entry_r),
    .read_error      (rerr_r),
    .table_base      (table_base_r),
    .state_cur       (walk_r),
    .state_nxt       (walk_nxt),
    .has_result      (has_res),
    .result          (res_nxt)
  );

  // configuration write, no handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_base_r <= '0;
    end else if (cfg_wr_en) begin
      table_base_r <= cfg_wr_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      func_r  <= in_func;
      va_r    <= in_virtual_address;
      entry_r <= in_entry_value;
      rerr_r  <= in_read_error;
    end
  end

  // walk state advances once per staged beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      walk_r <= '{busy: 1'b0, level: fltpw_pkg::LVL_PML4, saved_va: '0};
    end else if (step_go) begin
      walk_r <= walk_nxt;
    end
  end

  // result register; entries arriving while idle leave no result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (step_go && has_res) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go && has_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_kind    = res_r.kind;
  assign out_address = res_r.address;
  assign out_fault   = res_r.fault;

endmodule

// File: sv/fltpw_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fltpw_step
// one walk step: next walk state and result for a request or returned entry
// ----------------------------------------------------------------------------
module fltpw_step (
  input  logic                                  func,
  input  logic [fltpw_pkg::VaW-1:0]             virtual_address,
  input  logic [fltpw_pkg::EntryW-1:0]          entry_value,
  input  logic                                  read_error,
  input  logic [fltpw_pkg::PaW-1:0]             table_base,
  input  fltpw_pkg::walk_state_t                state_cur,
  output fltpw_pkg::walk_state_t                state_nxt,
  output logic                                  has_result,
  output fltpw_pkg::walk_result_t               result
);

  logic [fltpw_pkg::PaW-1:0] frame_4k;
  logic [fltpw_pkg::PaW-1:0] base_4k;
  logic                      large_pg;
  logic                      entry_bad;

  // entry address: 4k-aligned frame with the 9-bit index in bits 11:3
  function automatic logic [fltpw_pkg::PaW-1:0] entry_addr(
    input logic [fltpw_pkg::PaW-1:0] frame,
    input logic [fltpw_pkg::IdxW-1:0] idx
  );
    entry_addr = {frame[fltpw_pkg::PaW-1:12], idx, 3'b000};
  endfunction

  assign frame_4k  = {entry_value[fltpw_pkg::PaW-1:12], 12'h000};
  assign base_4k   = {table_base[fltpw_pkg::PaW-1:12], 12'h000};
  assign large_pg  = entry_value[fltpw_pkg::BitLarge];
  assign entry_bad = read_error || !entry_value[fltpw_pkg::BitPresent];

  always_comb begin
    state_nxt  = state_cur;
    has_result = 1'b0;
    result     = '{kind: fltpw_pkg::KIND_DONE, address: '0, fault: 1'b1};

    if (func == fltpw_pkg::FUNC_TRANSLATE) begin
      has_result = 1'b1;
      if (table_base == '0 || virtual_address == '0) begin
        state_nxt.busy  = 1'b0;
        state_nxt.level = fltpw_pkg::LVL_PML4;
      end else begin
        state_nxt.busy     = 1'b1;
        state_nxt.level    = fltpw_pkg::LVL_PML4;
        state_nxt.saved_va = virtual_address;
        result.kind        = fltpw_pkg::KIND_READ;
        result.fault       = 1'b0;
        result.address     = entry_addr(base_4k,
          virtual_address[fltpw_pkg::ShiftPml4 +: fltpw_pkg::IdxW]);
      end
    end else if (state_cur.busy) begin
      has_result = 1'b1;
      if (entry_bad) begin
        state_nxt.busy  = 1'b0;
        state_nxt.level = fltpw_pkg::LVL_PML4;
      end else begin
        result.fault = 1'b0;
        unique case (state_cur.level)
          fltpw_pkg::LVL_PML4: begin
            state_nxt.level = fltpw_pkg::LVL_PDPT;
            result.kind     = fltpw_pkg::KIND_READ;
            result.address  = entry_addr(frame_4k,
              state_cur.saved_va[fltpw_pkg::ShiftPdpt +: fltpw_pkg::IdxW]);
          end
          fltpw_pkg::LVL_PDPT: begin
            if (large_pg) begin
              state_nxt.busy  = 1'b0;
              state_nxt.level = fltpw_pkg::LVL_PML4;
              result.address  = {entry_value[fltpw_pkg::PaW-1:30],
                                 state_cur.saved_va[29:0]};
            end else begin
              state_nxt.level = fltpw_pkg::LVL_PD;
              result.kind     = fltpw_pkg::KIND_READ;
              result.address  = entry_addr(frame_4k,
                state_cur.saved_va[fltpw_pkg::ShiftPd +: fltpw_pkg::IdxW]);
            end
          end
          fltpw_pkg::LVL_PD: begin
            if (large_pg) begin
              state_nxt.busy  = 1'b0;
              state_nxt.level = fltpw_pkg::LVL_PML4;
              result.address  = {entry_value[fltpw_pkg::PaW-1:21],
                                 state_cur.saved_va[20:0]};
            end else begin
              state_nxt.level = fltpw_pkg::LVL_PT;
              result.kind     = fltpw_pkg::KIND_READ;
              result.address  = entry_addr(frame_4k,
                state_cur.saved_va[fltpw_pkg::ShiftPt +: fltpw_pkg::IdxW]);
            end
          end
          fltpw_pkg::LVL_PT: begin
            state_nxt.busy  = 1'b0;
            state_nxt.level = fltpw_pkg::LVL_PML4;
            result.address  = {entry_value[fltpw_pkg::PaW-1:12],
                               state_cur.saved_va[11:0]};
          end
          default: begin
            state_nxt.busy  = 1'b0;
            state_nxt.level = fltpw_pkg::LVL_PML4;
          end
        endcase
      end
    end
  end

endmodule

// File: tb/tb_page_walk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_walk_pkg
// walk prediction and result checking for the four-level page table walker
// ----------------------------------------------------------------------------
package tb_page_walk_pkg;

  import fltpw_pkg::*;

  class page_walk_scoreboard;
    logic [PaW-1:0]   table_base;
    level_t           level;
    logic             busy;
    logic [VaW-1:0]   saved_va;
    walk_result_t     expected_q[$];
    int unsigned      errors;

    function new();
      table_base = '0;
      level      = LVL_PML4;
      busy       = 1'b0;
      saved_va   = '0;
      errors     = 0;
    endfunction

    function void set_base(logic [PaW-1:0] value);
      table_base = value;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // entry address inside a table for the index taken at the given shift
    function logic [PaW-1:0] index_entry(logic [PaW-1:0] frame, int unsigned shift);
      logic [IdxW-1:0] idx;
      idx = IdxW'(saved_va >> shift);
      return frame + {idx, 3'b000};
    endfunction

    function walk_result_t close_walk(logic [PaW-1:0] pa, logic flt);
      walk_result_t r;
      busy      = 1'b0;
      level     = LVL_PML4;
      r.kind    = KIND_DONE;
      r.address = flt ? '0 : pa;
      r.fault   = flt;
      return r;
    endfunction

    function void note_beat(logic func, logic [VaW-1:0] va, logic [EntryW-1:0] entry,
                            logic rerr);
      walk_result_t   r;
      logic [PaW-1:0] frame;
      r.kind    = KIND_READ;
      r.address = '0;
      r.fault   = 1'b0;
      frame     = {entry[PaW-1:ShiftPt], 12'h000};
      if (func == FUNC_TRANSLATE) begin
        if (table_base == '0 || va == '0) begin
          r = close_walk('0, 1'b1);
        end else begin
          saved_va  = va;
          level     = LVL_PML4;
          busy      = 1'b1;
          r.address = index_entry({table_base[PaW-1:ShiftPt], 12'h000}, ShiftPml4);
        end
        expected_q.push_back(r);
        return;
      end
      // entry with no walk in progress is dropped
      if (!busy) return;
      if (rerr || !entry[BitPresent]) begin
        r = close_walk('0, 1'b1);
      end else begin
        case (level)
          LVL_PML4: begin
            level     = LVL_PDPT;
            r.address = index_entry(frame, ShiftPdpt);
          end
          LVL_PDPT: begin
            if (entry[BitLarge]) begin
              r = close_walk({entry[PaW-1:ShiftPdpt], saved_va[ShiftPdpt-1:0]}, 1'b0);
            end else begin
              level     = LVL_PD;
              r.address = index_entry(frame, ShiftPd);
            end
          end
          LVL_PD: begin
            if (entry[BitLarge]) begin
              r = close_walk({entry[PaW-1:ShiftPd], saved_va[ShiftPd-1:0]}, 1'b0);
            end else begin
              level     = LVL_PT;
              r.address = index_entry(frame, ShiftPt);
            end
          end
          default: begin
            r = close_walk({entry[PaW-1:ShiftPt], saved_va[ShiftPt-1:0]}, 1'b0);
          end
        endcase
      end
      expected_q.push_back(r);
    endfunction

    function void check_beat(logic kind, logic [PaW-1:0] address, logic fault);
      walk_result_t exp_r;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: kind %0d address %h fault %0d", kind, address, fault);
        errors++;
        return;
      end
      exp_r = expected_q.pop_front();
      if (kind !== exp_r.kind) begin
        $error("kind mismatch: expected %0d actual %0d", exp_r.kind, kind);
        errors++;
      end
      if (address !== exp_r.address) begin
        $error("address mismatch: expected %h actual %h", exp_r.address, address);
        errors++;
      end
      if (fault !== exp_r.fault) begin
        $error("fault mismatch: expected %0d actual %0d", exp_r.fault, fault);
        errors++;
      end
    endfunction
  endclass

endpackage

// File: tb/tb_four_level_page_table_walker_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_four_level_page_table_walker_unit
// drives translate requests and returned table entries into the walker,
// predicts every read request and finished translation, and checks each
// result beat in order under random idling on both channels
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_unit;

  import fltpw_pkg::*;
  import tb_page_walk_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned PhaseItems  = 155;
  localparam int unsigned HoldCycles  = 400;

  // directed entry patterns
  localparam logic [EntryW-1:0] EntAllOnes     = '1;
  localparam logic [EntryW-1:0] EntNoLarge     = 64'h7FFF_FFFF_FFFF_FF7F;
  localparam logic [EntryW-1:0] EntNotPresent  = 64'hFFFF_FFFF_FFFF_FFFE;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_wr_en = 1'b0;
  logic [PaW-1:0]     cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_func = 1'b0;
  logic [VaW-1:0]     in_virtual_address = '0;
  logic [EntryW-1:0]  in_entry_value = '0;
  logic               in_read_error = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               out_kind;
  logic [PaW-1:0]     out_address;
  logic               out_fault;

  page_walk_scoreboard sb;

  // shared between the stimulus and the result sink
  bit                 steady = 1'b0;       // no idling on either side
  int unsigned        hold_cycles = 0;     // long receiver hold-off request
  bit                 holding = 1'b0;      // receiver is in its hold-off
  int unsigned        cycle_count = 0;

  four_level_page_table_walker_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_func            (in_func),
    .in_virtual_address (in_virtual_address),
    .in_entry_value     (in_entry_value),
    .in_read_error      (in_read_error),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_kind           (out_kind),
    .out_address        (out_address),
    .out_fault          (out_fault)
  );

  always #10 clk = ~clk;

  // run limit, far above the slowest legal run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // both handshakes sampled at the edge; a result beat can never come from a
  // beat accepted at the same edge, so checking first is safe
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) sb.check_beat(out_kind, out_address, out_fault);
      if (in_valid && in_ready) begin
        sb.note_beat(in_func, in_virtual_address, in_entry_value, in_read_error);
      end
    end
  end

  // mostly no gap, some short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    return {$urandom, $urandom};
  endfunction

  // plain keeps away from the zero and all-ones corner addresses
  function automatic logic [VaW-1:0] rand_va(bit plain);
    int unsigned r;
    r = plain ? 99 : $urandom_range(0, 99);
    if (r < 3) return '0;
    if (r < 5) return '1;
    return VaW'({$urandom, $urandom}) | VaW'(1);
  endfunction

  // result sink: random stalls, ready runs, and the long hold-off on request
  initial begin : result_sink
    int unsigned stall;
    int unsigned run;
    @(posedge clk);
    forever begin
      if (hold_cycles != 0) begin
        stall = hold_cycles;
        out_ready <= 1'b0;
        holding = 1'b1;
        repeat (stall) @(posedge clk);
        holding = 1'b0;
        hold_cycles = 0;
      end
      stall = steady ? 0 : pick_gap();
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      run = steady ? $urandom_range(50, 200) : $urandom_range(1, 24);
      repeat (run) @(posedge clk);
    end
  end

  // one beat on the input channel; valid stays high into the next beat when
  // there is no gap
  task automatic send_beat(input logic func, input logic [VaW-1:0] va,
                           input logic [EntryW-1:0] entry, input logic rerr);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_func            <= func;
    in_virtual_address <= va;
    in_entry_value     <= entry;
    in_read_error      <= rerr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic write_table_base(input logic [PaW-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    sb.set_base(value);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // sender pause until every predicted beat has come back, plus pipeline slack
  // since a dropped entry beat may still be in flight; the first edge lets the
  // monitor note the last accepted beat before the count is read
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // one translation: request then entries down the levels, mostly well formed
  task automatic random_walk(inout int unsigned count);
    logic [VaW-1:0]     va;
    logic [EntryW-1:0]  e;
    logic               rerr;
    bit                 done;
    int unsigned        r;
    r = $urandom_range(0, 99);
    if (r < 4) begin
      // noise beat, anything goes
      send_beat(1'($urandom_range(0, 1)), rand_va(1'b0), rand_entry(),
                1'($urandom_range(0, 1)));
      return;
    end
    va = rand_va(1'b0);
    send_beat(FUNC_TRANSLATE, va, rand_entry(), 1'($urandom_range(0, 1)));
    count++;
    done = (sb.table_base == '0) || (va == '0);
    for (int lvl = 0; lvl < 4 && !done; lvl++) begin
      // walk abandoned midway, the next request restarts it
      if ($urandom_range(0, 99) < 4) break;
      e    = rand_entry();
      rerr = 1'b0;
      r    = $urandom_range(0, 99);
      if (r < 4) rerr = 1'b1;
      else if (r < 7) e = '0;
      else if (r < 10) e[BitPresent] = 1'b0;
      else e[BitPresent] = 1'b1;
      if (r >= 10) e[BitLarge] = ($urandom_range(0, 99) < 30);
      done = rerr || !e[BitPresent] || lvl == 3 || (e[BitLarge] && (lvl == 1 || lvl == 2));
      send_beat(FUNC_ENTRY, rand_va(1'b0), e, rerr);
      count++;
    end
    // stray entry beat after the walk
    if ($urandom_range(0, 99) < 3) send_beat(FUNC_ENTRY, rand_va(1'b0), rand_entry(), 1'b0);
  endtask

  initial begin : stimulus
    int unsigned      done_items;
    logic [PaW-1:0]   base_val;
    sb = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // base still zero from reset: request faults at once
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    drain_results();
    write_table_base('1);
    // zero address faults
    send_beat(FUNC_TRANSLATE, '0, rand_entry(), 1'b0);
    // all-ones address, large bit ignored at the top level, 1 GiB page
    send_beat(FUNC_TRANSLATE, '1, rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    // entry with no walk in progress is dropped
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    // 2 MiB page
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    // full 4 KiB walk, large bit ignored at the last level
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b1);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    // faults: zero entry, not present, read error
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), '0, 1'b0);
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNotPresent, 1'b0);
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b1);
    // new request mid-walk drops the old walk
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_TRANSLATE, rand_va(1'b1), rand_entry(), 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    // base rewritten while the walk is open: the walk keeps going
    drain_results();
    write_table_base(52'h0_0000_0000_1000);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntNoLarge, 1'b0);
    send_beat(FUNC_ENTRY, rand_va(1'b1), EntAllOnes, 1'b0);
    drain_results();

    // ---- random phases, one table base each ----
    for (int p = 0; p < 8; p++) begin
      case (p)
        1:       base_val = '1;
        3:       base_val = '0;                       // every request faults
        4:       base_val = 52'h0_0000_0000_0FFF;     // nonzero, but zero frame
        default: base_val = PaW'({$urandom, $urandom});
      endcase
      write_table_base(base_val);
      steady = (p == 2 || p == 5);
      if (p == 2) begin
        // receiver holds off while the sender keeps offering beats
        hold_cycles = HoldCycles;
        wait (holding);
      end
      done_items = 0;
      while (done_items < PhaseItems) random_walk(done_items);
      steady = 1'b0;
      drain_results();
    end

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
